[rtl/rmwalu_pkg.sv]
// ----------------------------------------------------------------------------
// rmwalu_pkg
// Shared types for the read-modify-write ALU: action codes and the payload
// structs passed between pipeline stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rmwalu_pkg;

  localparam int unsigned ActW  = 4;
  localparam int unsigned ByteW = 8;

  typedef enum logic [ActW-1:0] {
    ACT_ASL = 4'd0,
    ACT_LSR = 4'd1,
    ACT_ROL = 4'd2,
    ACT_ROR = 4'd3,
    ACT_INC = 4'd4,
    ACT_DEC = 4'd5,
    ACT_SLO = 4'd6,
    ACT_SRE = 4'd7,
    ACT_RLA = 4'd8,
    ACT_RRA = 4'd9,
    ACT_ISC = 4'd10,
    ACT_DCP = 4'd11
  } action_e;

  // raw input beat
  typedef struct packed {
    action_e          action;
    logic [ByteW-1:0] operand_byte;
    logic [ByteW-1:0] acc;
    logic             carry;
    logic             overflow;
  } req_t;

  // after the memory-modify stage
  typedef struct packed {
    action_e          action;
    logic [ByteW-1:0] mod_byte;
    logic [ByteW-1:0] acc;
    logic             carry;
    logic             overflow;
  } mod_t;

  // after the accumulator stage
  typedef struct packed {
    logic [ByteW-1:0] write_byte;
    logic [ByteW-1:0] acc;
    logic             carry;
    logic             overflow;
    logic [ByteW-1:0] flag_val;
  } accum_t;

  // final result beat
  typedef struct packed {
    logic [ByteW-1:0] write_byte;
    logic [ByteW-1:0] acc;
    logic             carry;
    logic             zero;
    logic             negative;
    logic             overflow;
  } res_t;

endpackage

`default_nettype wire

[rtl/rmwalu_in_if.sv]
// ----------------------------------------------------------------------------
// rmwalu_in_if
// Input channel: one instruction beat with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rmwalu_in_if;
  logic                          valid;
  logic                          ready;
  logic [rmwalu_pkg::ActW-1:0]   action;
  logic [rmwalu_pkg::ByteW-1:0]  operand_byte;
  logic [rmwalu_pkg::ByteW-1:0]  acc_in;
  logic                          carry_in;
  logic                          overflow_in;

  modport source (
    output valid, action, operand_byte, acc_in, carry_in, overflow_in,
    input  ready
  );
  modport sink (
    input  valid, action, operand_byte, acc_in, carry_in, overflow_in,
    output ready
  );
endinterface

`default_nettype wire

[rtl/rmwalu_out_if.sv]
// ----------------------------------------------------------------------------
// rmwalu_out_if
// Output channel: one result beat with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rmwalu_out_if;
  logic                          valid;
  logic                          ready;
  logic [rmwalu_pkg::ByteW-1:0]  write_byte;
  logic [rmwalu_pkg::ByteW-1:0]  acc_out;
  logic                          carry_out;
  logic                          zero_out;
  logic                          negative_out;
  logic                          overflow_out;

  modport source (
    output valid, write_byte, acc_out, carry_out, zero_out, negative_out,
           overflow_out,
    input  ready
  );
  modport sink (
    input  valid, write_byte, acc_out, carry_out, zero_out, negative_out,
           overflow_out,
    output ready
  );
endinterface

`default_nettype wire

[rtl/rmwalu_modify.sv]
// ----------------------------------------------------------------------------
// rmwalu_modify
// Stage 1: shift, rotate, increment or decrement of the memory byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rmwalu_modify (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 valid_i,
  output logic                ready_o,
  input  wire rmwalu_pkg::req_t data_i,
  output logic                valid_o,
  input  wire                 ready_i,
  output rmwalu_pkg::mod_t    data_o
);

  logic             valid_q;
  rmwalu_pkg::mod_t data_d, data_q;

  always_comb begin
    data_d.action   = data_i.action;
    data_d.acc      = data_i.acc;
    data_d.overflow = data_i.overflow;
    data_d.carry    = data_i.carry;
    data_d.mod_byte = data_i.operand_byte;
    case (data_i.action)
      rmwalu_pkg::ACT_ASL, rmwalu_pkg::ACT_SLO: begin
        data_d.carry    = data_i.operand_byte[7];
        data_d.mod_byte = {data_i.operand_byte[6:0], 1'b0};
      end
      rmwalu_pkg::ACT_LSR, rmwalu_pkg::ACT_SRE: begin
        data_d.carry    = data_i.operand_byte[0];
        data_d.mod_byte = {1'b0, data_i.operand_byte[7:1]};
      end
      rmwalu_pkg::ACT_ROL, rmwalu_pkg::ACT_RLA: begin
        data_d.carry    = data_i.operand_byte[7];
        data_d.mod_byte = {data_i.operand_byte[6:0], data_i.carry};
      end
      rmwalu_pkg::ACT_ROR, rmwalu_pkg::ACT_RRA: begin
        data_d.carry    = data_i.operand_byte[0];
        data_d.mod_byte = {data_i.carry, data_i.operand_byte[7:1]};
      end
      rmwalu_pkg::ACT_INC, rmwalu_pkg::ACT_ISC: begin
        data_d.mod_byte = data_i.operand_byte + 8'd1;
      end
      rmwalu_pkg::ACT_DEC, rmwalu_pkg::ACT_DCP: begin
        data_d.mod_byte = data_i.operand_byte - 8'd1;
      end
      default: begin
        data_d.mod_byte = data_i.operand_byte;
      end
    endcase
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

[rtl/rmwalu_accum.sv]
// ----------------------------------------------------------------------------
// rmwalu_accum
// Stage 2: accumulator step (ORA, EOR, AND, ADC, SBC, CMP) on one adder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rmwalu_accum (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 valid_i,
  output logic                ready_o,
  input  wire rmwalu_pkg::mod_t data_i,
  output logic                valid_o,
  input  wire                 ready_i,
  output rmwalu_pkg::accum_t  data_o
);

  logic               valid_q;
  rmwalu_pkg::accum_t data_d, data_q;
  logic [7:0]         add_b;
  logic               add_cin;
  logic [8:0]         sum;

  // SBC and CMP add the inverted byte; CMP forces the carry in
  always_comb begin
    add_b   = data_i.mod_byte;
    add_cin = data_i.carry;
    if (data_i.action == rmwalu_pkg::ACT_ISC) begin
      add_b = ~data_i.mod_byte;
    end else if (data_i.action == rmwalu_pkg::ACT_DCP) begin
      add_b   = ~data_i.mod_byte;
      add_cin = 1'b1;
    end
    sum = {1'b0, data_i.acc} + {1'b0, add_b} + {8'd0, add_cin};
  end

  always_comb begin
    data_d.write_byte = data_i.mod_byte;
    data_d.acc        = data_i.acc;
    data_d.carry      = data_i.carry;
    data_d.overflow   = data_i.overflow;
    data_d.flag_val   = data_i.mod_byte;
    case (data_i.action)
      rmwalu_pkg::ACT_SLO: begin
        data_d.acc      = data_i.acc | data_i.mod_byte;
        data_d.flag_val = data_i.acc | data_i.mod_byte;
      end
      rmwalu_pkg::ACT_SRE: begin
        data_d.acc      = data_i.acc ^ data_i.mod_byte;
        data_d.flag_val = data_i.acc ^ data_i.mod_byte;
      end
      rmwalu_pkg::ACT_RLA: begin
        data_d.acc      = data_i.acc & data_i.mod_byte;
        data_d.flag_val = data_i.acc & data_i.mod_byte;
      end
      rmwalu_pkg::ACT_RRA, rmwalu_pkg::ACT_ISC: begin
        data_d.acc      = sum[7:0];
        data_d.flag_val = sum[7:0];
        data_d.carry    = sum[8];
        data_d.overflow = ~(data_i.acc[7] ^ add_b[7]) & (data_i.acc[7] ^ sum[7]);
      end
      rmwalu_pkg::ACT_DCP: begin
        data_d.carry    = sum[8];
        data_d.flag_val = sum[7:0];
      end
      default: begin
        data_d.flag_val = data_i.mod_byte;
      end
    endcase
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

[rtl/rmwalu_flags.sv]
// ----------------------------------------------------------------------------
// rmwalu_flags
// Stage 3: zero and negative flags, output register of the unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rmwalu_flags (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 valid_i,
  output logic                ready_o,
  input  wire rmwalu_pkg::accum_t data_i,
  output logic                valid_o,
  input  wire                 ready_i,
  output rmwalu_pkg::res_t    data_o
);

  logic             valid_q;
  rmwalu_pkg::res_t data_d, data_q;

  always_comb begin
    data_d.write_byte = data_i.write_byte;
    data_d.acc        = data_i.acc;
    data_d.carry      = data_i.carry;
    data_d.overflow   = data_i.overflow;
    data_d.zero       = (data_i.flag_val == 8'd0);
    data_d.negative   = data_i.flag_val[7];
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

[rtl/rmw_shift_rotate_alu.sv]
// ----------------------------------------------------------------------------
// rmw_shift_rotate_alu
// path: input beat to result beat through modify, accumulate and flags
// throughput: one beat per cycle, each stage register holds under backpressure
// a stalled output lets the stages behind it fill up before input ready drops
// reset: asynchronous, clears the three stage valid bits only
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rmw_shift_rotate_alu (
  input  wire          clk_i,
  input  wire          rst_ni,
  rmwalu_in_if.sink    in_i,
  rmwalu_out_if.source out_o
);

  rmwalu_pkg::req_t   req;
  rmwalu_pkg::mod_t   mod_data;
  rmwalu_pkg::accum_t acc_data;
  rmwalu_pkg::res_t   res_data;
  logic               mod_valid, mod_ready;
  logic               acc_valid, acc_ready;

  assign req.action       = rmwalu_pkg::action_e'(in_i.action);
  assign req.operand_byte = in_i.operand_byte;
  assign req.acc          = in_i.acc_in;
  assign req.carry        = in_i.carry_in;
  assign req.overflow     = in_i.overflow_in;

  rmwalu_modify u_modify (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .data_i  (req),
    .valid_o (mod_valid),
    .ready_i (mod_ready),
    .data_o  (mod_data)
  );

  rmwalu_accum u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mod_valid),
    .ready_o (mod_ready),
    .data_i  (mod_data),
    .valid_o (acc_valid),
    .ready_i (acc_ready),
    .data_o  (acc_data)
  );

  rmwalu_flags u_flags (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (acc_valid),
    .ready_o (acc_ready),
    .data_i  (acc_data),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .data_o  (res_data)
  );

  assign out_o.write_byte   = res_data.write_byte;
  assign out_o.acc_out      = res_data.acc;
  assign out_o.carry_out    = res_data.carry;
  assign out_o.zero_out     = res_data.zero;
  assign out_o.negative_out = res_data.negative;
  assign out_o.overflow_out = res_data.overflow;

`ifndef SYNTH
  // input only backs up once every stage holds a beat
  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (mod_valid && acc_valid && out_o.valid))
    else $error("input stalled with an empty stage");

  // a stage 1 beat blocked by stage 2 stays put
  a_mod_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mod_valid && !mod_ready) |=> (mod_valid && $stable(mod_data)))
    else $error("stage 1 beat changed while stalled");

  // a stage 2 beat blocked by the output stays put
  a_acc_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_valid && !acc_ready) |=> (acc_valid && $stable(acc_data)))
    else $error("stage 2 beat changed while stalled");

  // output stage takes a beat whenever stage 2 offers one and it is free
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_valid && acc_ready) |=> out_o.valid)
    else $error("stage 2 beat lost on transfer");
`endif

endmodule

`default_nettype wire
